FILE: design/palette_remap_blit_assert.svh
// Assertion macros used by the palette remap blitter top level.
`ifndef PALETTE_REMAP_BLIT_ASSERT_SVH
`define PALETTE_REMAP_BLIT_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define PRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette remap: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define PRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette remap: next-cycle check failed");

`endif

FILE: design/prb_pkg.sv
// Types, constants and helper functions for the palette remap blitter.
`default_nettype none

package prb_pkg;

    localparam int DEF_PALETTE_SIZE = 256;
    localparam int TABLE_DEPTH      = 256;
    localparam int IDX_FIELD_W      = 8;
    localparam int COLOUR_W         = 24;
    localparam int DIST_W           = 18;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // request type codes on the input port
    localparam logic [1:0] REQ_SRC_WR = 2'd0;
    localparam logic [1:0] REQ_DST_WR = 2'd1;
    localparam logic [1:0] REQ_PIXEL  = 2'd2;

    typedef enum logic [1:0] {
        CMD_SRC_WR,
        CMD_DST_WR,
        CMD_PIXEL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [IDX_FIELD_W-1:0]   idx;
        logic [COLOUR_W-1:0]      colour;
        logic                     start;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SEARCH,
        ST_EMIT
    } back_state_t;

    // squared RGB distance between two packed colours
    function automatic logic [DIST_W-1:0] rgb_dist(input logic [COLOUR_W-1:0] p,
                                                   input logic [COLOUR_W-1:0] q);
        logic [7:0]  dr;
        logic [7:0]  dg;
        logic [7:0]  db;
        logic [15:0] sr;
        logic [15:0] sg;
        logic [15:0] sb;
        dr = (p[23:16] > q[23:16]) ? (p[23:16] - q[23:16]) : (q[23:16] - p[23:16]);
        dg = (p[15:8] > q[15:8]) ? (p[15:8] - q[15:8]) : (q[15:8] - p[15:8]);
        db = (p[7:0] > q[7:0]) ? (p[7:0] - q[7:0]) : (q[7:0] - p[7:0]);
        sr = {8'd0, dr} * {8'd0, dr};
        sg = {8'd0, dg} * {8'd0, dg};
        sb = {8'd0, db} * {8'd0, db};
        return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    endfunction

endpackage

`default_nettype wire

FILE: design/prb_front.sv
// Front end: takes requests, classifies them and drops those with no effect.
`default_nettype none

module prb_front import prb_pkg::*; #(
    parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             req_type,
    input  wire logic [IDX_FIELD_W-1:0] entry_index,
    input  wire logic [7:0]             red,
    input  wire logic [7:0]             green,
    input  wire logic [7:0]             blue,
    input  wire logic [IDX_FIELD_W-1:0] source_index,
    input  wire logic                   blit_start,
    input  wire qstat_t                 qstat,
    output logic                        q_push,
    output cmd_t                        q_cmd
);

    localparam logic [IDX_FIELD_W:0] PAL_LIMIT = PALETTE_SIZE[IDX_FIELD_W:0];

    logic entry_ok;
    logic keep;

    assign entry_ok = {1'b0, entry_index} < PAL_LIMIT;

    always_comb
    begin
        q_cmd.colour = {red, green, blue};
        q_cmd.start  = blit_start;
        q_cmd.idx    = entry_index;
        q_cmd.kind   = CMD_PIXEL;
        keep         = 1'b0;
        case (req_type)
            REQ_SRC_WR:
            begin
                q_cmd.kind = CMD_SRC_WR;
                keep       = entry_ok;
            end
            REQ_DST_WR:
            begin
                q_cmd.kind = CMD_DST_WR;
                keep       = entry_ok;
            end
            REQ_PIXEL:
            begin
                q_cmd.kind = CMD_PIXEL;
                q_cmd.idx  = source_index;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // dropped requests are still taken, they just never reach the queue
    assign full   = qstat.full;
    assign q_push = push && !qstat.full && keep;

endmodule

`default_nettype wire

FILE: design/prb_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module prb_queue import prb_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_push,
    input  wire cmd_t q_cmd_in,
    input  wire logic q_pop,
    output cmd_t      q_cmd_out,
    output qstat_t    qstat
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (q_push && !q_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (q_pop && !q_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            slot_reg[wr_ptr_reg] <= q_cmd_in;
    end

    assign q_cmd_out   = slot_reg[rd_ptr_reg];
    assign qstat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign qstat.empty = count_reg == '0;

endmodule

`default_nettype wire

FILE: design/prb_back.sv
// Back end: palettes, remap cache, nearest-colour search and result register.
`default_nettype none

module prb_back import prb_pkg::*; #(
    parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire qstat_t                 qstat,
    input  wire cmd_t                   q_cmd,
    output logic                        q_pop,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [IDX_FIELD_W-1:0]      dest_index,
    output logic                        write_enable,
    output logic                        res_load
);

    localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
    localparam logic [IDX_FIELD_W:0] PAL_LIMIT = PALETTE_SIZE[IDX_FIELD_W:0];
    localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(PALETTE_SIZE - 1);
    localparam logic [CNT_W-1:0]     PAL_END   = CNT_W'(PALETTE_SIZE);

    // storage
    logic [COLOUR_W-1:0]    src_mem   [PALETTE_SIZE];
    logic [COLOUR_W-1:0]    dst_mem   [PALETTE_SIZE];
    logic [IDX_FIELD_W-1:0] cache_mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0]  cvalid_reg;

    logic [COLOUR_W-1:0]    src_q;
    logic [COLOUR_W-1:0]    dst_q;
    logic [IDX_FIELD_W-1:0] cache_q;

    // palette clearing pass after reset
    logic                   clr_busy_reg;
    logic [IDX_W-1:0]       clr_addr_reg;

    // state and working registers
    back_state_t            state_reg, state_next;
    logic                   out_vld_reg;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_FIELD_W-1:0] idx_reg, idx_next;
    logic [COLOUR_W-1:0]    target_reg, target_next;
    logic [CNT_W-1:0]       srch_reg, srch_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [DIST_W-1:0]      best_reg, best_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic [IDX_FIELD_W-1:0] res_idx_reg, res_idx_next;
    logic                   res_we_reg, res_we_next;
    logic [IDX_FIELD_W-1:0] dest_index_reg;
    logic                   write_enable_reg;

    // controls
    logic                   src_we;
    logic                   dst_we;
    logic                   rd_en;
    logic                   dst_re;
    logic                   cache_clr;
    logic                   cache_we;
    logic [IDX_FIELD_W-1:0] cache_wdata;
    logic                   out_load;
    logic [IDX_FIELD_W-1:0] out_idx;
    logic                   out_we;
    logic                   emit_req;
    logic [IDX_FIELD_W-1:0] emit_idx;
    logic                   emit_we;

    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    dst_addr;
    logic                src_wr;
    logic                dst_wr;
    logic [IDX_W-1:0]    pal_waddr;
    logic [COLOUR_W-1:0] pal_wdata;
    logic                in_range;
    logic [COLOUR_W-1:0] sc;
    logic [COLOUR_W-1:0] dc;
    logic                hit;
    logic [COLOUR_W-1:0] cur_col;
    logic [DIST_W-1:0]   cur_dist;
    logic                take;
    logic [DIST_W-1:0]   new_best;
    logic [IDX_W-1:0]    new_pick;
    logic                srch_done;
    logic                out_free;

    assign rd_addr  = q_cmd.idx[IDX_W-1:0];
    assign dst_addr = (state_reg == ST_SEARCH) ? srch_reg[IDX_W-1:0] : rd_addr;

    // the clearing pass owns the palette write port until it is done
    assign src_wr    = src_we || clr_busy_reg;
    assign dst_wr    = dst_we || clr_busy_reg;
    assign pal_waddr = clr_busy_reg ? clr_addr_reg : rd_addr;
    assign pal_wdata = clr_busy_reg ? '0 : q_cmd.colour;

    // after reset the palettes are zeroed entry by entry, from address 0 up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == LAST_IDX)
                clr_busy_reg <= 1'b0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (src_wr)
            src_mem[pal_waddr] <= pal_wdata;
        if (rd_en)
            src_q <= src_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dst_wr)
            dst_mem[pal_waddr] <= pal_wdata;
        if (dst_re)
            dst_q <= dst_mem[dst_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cache_we)
            cache_mem[idx_reg] <= cache_wdata;
        if (rd_en)
            cache_q <= cache_mem[q_cmd.idx];
    end

    // cache valid bits; a blit start on a pixel request drops them all
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= '0;
        end
        else
        begin
            if (cache_clr)
                cvalid_reg <= '0;
            else if (cache_we)
                cvalid_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (pop)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        target_reg  <= target_next;
        srch_reg    <= srch_next;
        cmp_idx_reg <= cmp_idx_next;
        best_reg    <= best_next;
        pick_reg    <= pick_next;
        res_idx_reg <= res_idx_next;
        res_we_reg  <= res_we_next;
        if (out_load)
        begin
            dest_index_reg   <= out_idx;
            write_enable_reg <= out_we;
        end
    end

    // datapath
    assign in_range = {1'b0, idx_reg} < PAL_LIMIT;
    assign sc       = in_range ? src_q : '0;
    assign dc       = in_range ? dst_q : '0;
    assign hit      = cvalid_reg[idx_reg];
    assign cur_col  = dst_q;
    assign cur_dist = rgb_dist(cur_col, target_reg);
    // entry 0 always seeds the running best; ties keep the lower index
    assign take     = (cmp_idx_reg == '0) || (cur_dist < best_reg);
    assign new_best = take ? cur_dist : best_reg;
    assign new_pick = take ? cmp_idx_reg : pick_reg;
    // an exact match cannot be beaten, so the scan stops there
    assign srch_done = cmp_vld_reg && ((cmp_idx_reg == LAST_IDX) || (new_best == '0));
    assign out_free  = !out_vld_reg || pop;

    always_comb
    begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        src_we       = 1'b0;
        dst_we       = 1'b0;
        rd_en        = 1'b0;
        dst_re       = 1'b0;
        cache_clr    = 1'b0;
        cache_we     = 1'b0;
        cache_wdata  = '0;
        idx_next     = idx_reg;
        target_next  = target_reg;
        srch_next    = srch_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        res_idx_next = res_idx_reg;
        res_we_next  = res_we_reg;
        out_load     = 1'b0;
        out_idx      = '0;
        out_we       = 1'b0;
        emit_req     = 1'b0;
        emit_idx     = '0;
        emit_we      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty && !clr_busy_reg)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_SRC_WR:
                        begin
                            src_we = 1'b1;
                        end
                        CMD_DST_WR:
                        begin
                            dst_we = 1'b1;
                        end
                        CMD_PIXEL:
                        begin
                            cache_clr = q_cmd.start;
                            idx_next  = q_cmd.idx;
                            if (q_cmd.idx == '0)
                            begin
                                emit_req = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                dst_re     = 1'b1;
                                state_next = ST_LOOKUP;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (hit)
                begin
                    emit_req = 1'b1;
                    emit_idx = cache_q;
                    emit_we  = 1'b1;
                end
                else if (in_range && (sc == dc))
                begin
                    cache_we    = 1'b1;
                    cache_wdata = idx_reg;
                    emit_req    = 1'b1;
                    emit_idx    = idx_reg;
                    emit_we     = 1'b1;
                end
                else
                begin
                    target_next = sc;
                    srch_next   = '0;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (srch_reg < PAL_END)
                begin
                    dst_re       = 1'b1;
                    srch_next    = srch_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = srch_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg)
                begin
                    best_next = new_best;
                    pick_next = new_pick;
                end
                if (srch_done)
                begin
                    cmp_vld_next = 1'b0;
                    cache_we     = 1'b1;
                    cache_wdata  = IDX_FIELD_W'(new_pick);
                    emit_req     = 1'b1;
                    emit_idx     = IDX_FIELD_W'(new_pick);
                    emit_we      = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_idx    = res_idx_reg;
                    out_we     = res_we_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a finished result goes straight out if the slot is free, else it waits
        if (emit_req)
        begin
            if (out_free)
            begin
                out_load   = 1'b1;
                out_idx    = emit_idx;
                out_we     = emit_we;
                state_next = ST_IDLE;
            end
            else
            begin
                res_idx_next = emit_idx;
                res_we_next  = emit_we;
                state_next   = ST_EMIT;
            end
        end
    end

    assign empty        = !out_vld_reg;
    assign dest_index   = dest_index_reg;
    assign write_enable = write_enable_reg;
    assign res_load     = out_load;

endmodule

`default_nettype wire

FILE: design/palette_remap_blit.sv
// Top level of the palette remap blitter.
//
//  channel  | handshake      | fields
//  ---------+----------------+--------------------------------------------------
//  request  | push / full    | req_type, entry_index, red, green, blue,
//           |                | source_index, blit_start
//  result   | empty / pop    | dest_index, write_enable
//
// A palette write or a transparent pixel is done in the back end's idle state; a cache
// hit or an identity mapping also passes the lookup state. A miss then scans the
// destination palette one entry a cycle, stopping early when an exact match turns up.
// After reset the back end zeroes both palettes before it takes a request; cache
// valid bits clear at once. The two-entry queue takes two requests while the back end
// is busy, then full rises; a result waits in the back end while the output is full.
`default_nettype none

`include "palette_remap_blit_assert.svh"

module palette_remap_blit import prb_pkg::*; #(
    parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             req_type,
    input  wire logic [IDX_FIELD_W-1:0] entry_index,
    input  wire logic [7:0]             red,
    input  wire logic [7:0]             green,
    input  wire logic [7:0]             blue,
    input  wire logic [IDX_FIELD_W-1:0] source_index,
    input  wire logic                   blit_start,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [IDX_FIELD_W-1:0]      dest_index,
    output logic                        write_enable
);

    qstat_t qstat;
    logic   q_push;
    logic   q_pop;
    cmd_t   cmd_in;
    cmd_t   cmd_head;
    logic   res_load;

    // front end: classifies each request, drops those that change nothing
    prb_front #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_front (
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .source_index (source_index),
        .blit_start   (blit_start),
        .qstat        (qstat),
        .q_push       (q_push),
        .q_cmd        (cmd_in)
    );

    // decoupling queue
    prb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_push    (q_push),
        .q_cmd_in  (cmd_in),
        .q_pop     (q_pop),
        .q_cmd_out (cmd_head),
        .qstat     (qstat)
    );

    // back end: palettes, cache, search and the result register
    prb_back #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .q_cmd        (cmd_head),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .dest_index   (dest_index),
        .write_enable (write_enable),
        .res_load     (res_load)
    );

    // front never writes a full queue, back never takes from an empty one
    `PRB_ASSERT_NOW(a_push_room, clk, rst_n, q_push, !qstat.full)
    `PRB_ASSERT_NOW(a_pop_stocked, clk, rst_n, q_pop, !qstat.empty)
    // a result is only loaded into a free or departing output slot
    `PRB_ASSERT_NOW(a_load_free, clk, rst_n, res_load, empty || pop)
    // a taken result with nothing behind it leaves the output empty
    `PRB_ASSERT_NEXT(a_drain, clk, rst_n, pop && !empty && !res_load, empty)

endmodule

`default_nettype wire

FILE: verif/tb_palette_remap_blit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the palette remap blitter: directed, random and back-pressure runs.
module tb_palette_remap_blit;
    import prb_pkg::*;

    localparam int PAL_SIZE        = DEF_PALETTE_SIZE;
    localparam int CYCLE_LIMIT     = 3000000;
    // worst back-end occupancy is a full palette scan
    localparam int DRAIN_CYCLES    = PAL_SIZE + 16;
    localparam int ITEMS_PER_PHASE = 580;
    localparam int HOLD_OFF_CYCLES = 300;
    // request code the block has to drop
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] dest_index;
        logic                   write_enable;
    } remap_result_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   push         = 1'b0;
    logic                   full;
    logic [1:0]             req_type     = REQ_SRC_WR;
    logic [IDX_FIELD_W-1:0] entry_index  = '0;
    logic [7:0]             red          = '0;
    logic [7:0]             green        = '0;
    logic [7:0]             blue         = '0;
    logic [IDX_FIELD_W-1:0] source_index = '0;
    logic                   blit_start   = 1'b0;
    logic                   empty;
    logic                   pop          = 1'b0;
    logic [IDX_FIELD_W-1:0] dest_index;
    logic                   write_enable;

    // predictor state
    logic [COLOUR_W-1:0]    src_colours[TABLE_DEPTH];
    logic [COLOUR_W-1:0]    dst_colours[TABLE_DEPTH];
    logic [IDX_FIELD_W-1:0] remap_memo[TABLE_DEPTH];
    bit                     memo_valid[TABLE_DEPTH];
    remap_result_t          pending_results[$];

    // stimulus shaping
    logic [COLOUR_W-1:0]    colour_pool[8];
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     hold_left     = 0;

    // bookkeeping
    int unsigned            cycle_count        = 0;
    int unsigned            fail_count         = 0;
    int unsigned            requests_sent      = 0;
    int unsigned            pixels_sent        = 0;
    int unsigned            transparent_sent   = 0;
    int unsigned            results_checked    = 0;
    int unsigned            input_stall_cycles = 0;

    palette_remap_blit #(
        .PALETTE_SIZE (PAL_SIZE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .source_index (source_index),
        .blit_start   (blit_start),
        .empty        (empty),
        .pop          (pop),
        .dest_index   (dest_index),
        .write_enable (write_enable)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int unsigned colour_distance(input logic [COLOUR_W-1:0] a,
                                                    input logic [COLOUR_W-1:0] b);
        int unsigned total;
        int          d;
        total = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = int'(a[c*8 +: 8]) - int'(b[c*8 +: 8]);
            total += d * d;
        end
        return total;
    endfunction

    // first destination entry at least distance; an exact hit ends the scan
    function automatic logic [IDX_FIELD_W-1:0] nearest_dest_entry(
        input logic [COLOUR_W-1:0] colour);
        int unsigned best;
        int unsigned cand_dist;
        int          pick;
        best = 32'hFFFF_FFFF;
        pick = 0;
        for (int i = 0; i < PAL_SIZE && i < TABLE_DEPTH; i++)
        begin
            cand_dist = colour_distance(dst_colours[i], colour);
            if (cand_dist < best)
            begin
                best = cand_dist;
                pick = i;
                if (cand_dist == 0)
                    break;
            end
        end
        return pick[IDX_FIELD_W-1:0];
    endfunction

    function automatic void apply_request(input logic [1:0]             kind,
                                          input logic [IDX_FIELD_W-1:0] entry,
                                          input logic [COLOUR_W-1:0]    colour,
                                          input logic [IDX_FIELD_W-1:0] sidx,
                                          input logic                   start);
        logic [COLOUR_W-1:0] sc;
        logic [COLOUR_W-1:0] dc;
        logic                in_range;
        remap_result_t       res;
        if (kind == REQ_SRC_WR || kind == REQ_DST_WR)
        begin
            if (int'(entry) < PAL_SIZE)
            begin
                if (kind == REQ_SRC_WR)
                    src_colours[entry] = colour;
                else
                    dst_colours[entry] = colour;
            end
        end
        else if (kind == REQ_PIXEL)
        begin
            if (start)
                foreach (memo_valid[i])
                    memo_valid[i] = 1'b0;
            if (sidx == '0)
            begin
                res.dest_index   = '0;
                res.write_enable = 1'b0;
            end
            else
            begin
                if (!memo_valid[sidx])
                begin
                    // out-of-range indices see black in both palettes and always search
                    in_range = int'(sidx) < PAL_SIZE;
                    sc = in_range ? src_colours[sidx] : '0;
                    dc = in_range ? dst_colours[sidx] : '0;
                    remap_memo[sidx] = (in_range && sc == dc) ? sidx : nearest_dest_entry(sc);
                    memo_valid[sidx] = 1'b1;
                end
                res.dest_index   = remap_memo[sidx];
                res.write_enable = 1'b1;
            end
            pending_results.push_back(res);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request side: one request per call, starting and ending on a falling edge
    // ---------------------------------------------------------------
    task automatic send_request(input logic [1:0]             kind,
                                input logic [IDX_FIELD_W-1:0] entry,
                                input logic [COLOUR_W-1:0]    colour,
                                input logic [IDX_FIELD_W-1:0] sidx,
                                input logic                   start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        req_type     <= kind;
        entry_index  <= entry;
        red          <= colour[23:16];
        green        <= colour[15:8];
        blue         <= colour[7:0];
        source_index <= sidx;
        blit_start   <= start;
        @(posedge clk);
        while (full)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        apply_request(kind, entry, colour, sidx, start);
        if (kind != REQ_UNUSED)
            requests_sent++;
        if (kind == REQ_PIXEL)
        begin
            pixels_sent++;
            if (sidx == '0)
                transparent_sent++;
        end
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Result side: random pop, with an optional long hold-off
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        remap_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got dest_index %0d we %0b",
                         $time, dest_index, write_enable);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (dest_index !== want.dest_index)
                begin
                    $display("%0t: dest_index mismatch, expected %0d, got %0d",
                             $time, want.dest_index, dest_index);
                    fail_count++;
                end
                if (write_enable !== want.write_enable)
                begin
                    $display("%0t: write_enable mismatch, expected %0b, got %0b",
                             $time, want.write_enable, write_enable);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // pool colours make exact matches, identity mappings and ties likely
    function automatic logic [COLOUR_W-1:0] pick_colour();
        if ($urandom_range(3) == 0)
            return COLOUR_W'($urandom);
        return colour_pool[$urandom_range(7)];
    endfunction

    // one blit: palette loads, then a pixel run mostly over a small hot set of indices
    task automatic run_blit();
        logic [IDX_FIELD_W-1:0] hot[12];
        logic [IDX_FIELD_W-1:0] entry;
        logic [IDX_FIELD_W-1:0] sidx;
        logic [COLOUR_W-1:0]    colour;
        logic [1:0]             kind;
        logic                   start;
        logic                   skip_start;
        int                     n_writes;
        int                     n_pixels;
        foreach (colour_pool[i])
            if ($urandom_range(3) == 0)
                colour_pool[i] = COLOUR_W'($urandom);
        foreach (hot[i])
            hot[i] = rand_byte();
        n_writes = $urandom_range(16);
        for (int w = 0; w < n_writes; w++)
        begin
            entry  = $urandom_range(1) ? hot[$urandom_range(11)] : rand_byte();
            colour = pick_colour();
            kind   = $urandom_range(1) ? REQ_DST_WR : REQ_SRC_WR;
            // blit_start on a palette write must be ignored
            send_request(kind, entry, colour, rand_byte(), 1'($urandom_range(1)));
            // same colour in the other palette gives an identity mapping
            if ($urandom_range(2) == 0)
                send_request(kind == REQ_SRC_WR ? REQ_DST_WR : REQ_SRC_WR, entry, colour,
                             rand_byte(), 1'b0);
        end
        // now and then carry on with the previous blit's cache
        skip_start = ($urandom_range(5) == 0);
        n_pixels   = $urandom_range(8, 40);
        for (int p = 0; p < n_pixels; p++)
        begin
            case ($urandom_range(19))
                0, 1:    sidx = '0;
                2:       sidx = rand_byte();
                default: sidx = hot[$urandom_range(11)];
            endcase
            start = (p == 0 && !skip_start) || ($urandom_range(49) == 0);
            send_request(REQ_PIXEL, rand_byte(), COLOUR_W'($urandom), sidx, start);
            case ($urandom_range(29))
                0: send_request(REQ_UNUSED, rand_byte(), COLOUR_W'($urandom), rand_byte(),
                                1'($urandom_range(1)));
                // palette change mid-blit, stale mappings stay cached
                1: send_request($urandom_range(1) ? REQ_DST_WR : REQ_SRC_WR,
                                hot[$urandom_range(11)], pick_colour(), rand_byte(), 1'b0);
                default: ;
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // reset palettes are all black: transparent, then identity at both ends
        send_request(REQ_PIXEL, 8'hFF, 24'hFFFFFF, 8'd0, 1'b1);
        send_request(REQ_PIXEL, 8'h00, 24'h000000, 8'd1, 1'b0);
        send_request(REQ_PIXEL, 8'hFF, 24'hFFFFFF, 8'd255, 1'b0);
        send_request(REQ_UNUSED, 8'hFF, 24'hFFFFFF, 8'd255, 1'b1);
        // white source against all-black destination: every entry ties, lowest wins
        send_request(REQ_SRC_WR, 8'd10, 24'hFFFFFF, 8'd0, 1'b0);
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd10, 1'b1);
        // palette write mid-blit leaves the cached mapping alone
        send_request(REQ_DST_WR, 8'd200, 24'hFFFFFF, 8'd0, 1'b0);
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd10, 1'b0);
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd10, 1'b1);
        send_request(REQ_DST_WR, 8'd150, 24'hFFFFFF, 8'd0, 1'b0);
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd10, 1'b0);
        // blit_start on a transparent pixel still clears the cache
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd0, 1'b1);
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd10, 1'b0);
        // blit_start on a palette write is ignored
        send_request(REQ_DST_WR, 8'd100, 24'hFFFFFF, 8'd0, 1'b1);
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd10, 1'b0);
        // equal distances either side of the source colour
        send_request(REQ_SRC_WR, 8'd20, 24'h808080, 8'd0, 1'b0);
        send_request(REQ_DST_WR, 8'd30, 24'h7F8080, 8'd0, 1'b0);
        send_request(REQ_DST_WR, 8'd31, 24'h818080, 8'd0, 1'b0);
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd20, 1'b1);
        // identity on the top entry with a non-black colour
        send_request(REQ_SRC_WR, 8'd255, 24'h000001, 8'd0, 1'b0);
        send_request(REQ_DST_WR, 8'd255, 24'h000001, 8'd0, 1'b0);
        send_request(REQ_PIXEL, 8'hFF, 24'hFFFFFF, 8'd255, 1'b0);
        // destination entry 0 takes part in the search
        send_request(REQ_DST_WR, 8'd0, 24'h123456, 8'd0, 1'b0);
        send_request(REQ_SRC_WR, 8'd40, 24'h123456, 8'd0, 1'b0);
        send_request(REQ_PIXEL, 8'd0, 24'h0, 8'd40, 1'b1);
    endtask

    task automatic test_random_blits(input int s_pct, input int r_pct);
        int unsigned first;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        first = requests_sent;
        while (requests_sent - first < ITEMS_PER_PHASE)
            run_blit();
    endtask

    // result side holds off long enough for the request queue to fill
    task automatic test_full_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_OFF_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 5 == 4)
                send_request(REQ_DST_WR, rand_byte(), pick_colour(), rand_byte(), 1'b0);
            else
                send_request(REQ_PIXEL, rand_byte(), COLOUR_W'($urandom),
                             8'($urandom_range(4)), i == 0);
        end
    endtask

    initial
    begin
        foreach (src_colours[i])
        begin
            src_colours[i] = '0;
            dst_colours[i] = '0;
            remap_memo[i]  = '0;
            memo_valid[i]  = 1'b0;
        end
        foreach (colour_pool[i])
            colour_pool[i] = COLOUR_W'($urandom);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_blits(19, 64);
        test_random_blits(64, 19);
        test_random_blits(0, 0);
        test_full_backpressure();

        push <= 1'b0;
        recv_idle_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // a stray late result would still be caught here
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d pixels (%0d transparent), %0d results checked.",
                 requests_sent, pixels_sent, transparent_sent, results_checked);
        $display("Request side was held back by a full queue for %0d cycles.",
                 input_stall_cycles);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
